[rtl/core/flptw_pkg.sv]
// Shared types and constants of the four-level page-table walker.
// Holds entry layout, command/status codes and the microcode table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flptw_pkg;

  // Pool geometry
  localparam int NUM_FRAMES    = 64;
  localparam int ROOT_FRAMES   = 4;
  localparam int TABLE_ENTRIES = 512;

  localparam int INDEX_W  = $clog2(TABLE_ENTRIES);
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int FREE_W   = $clog2(NUM_FRAMES + 1);
  localparam int ADDR_W   = FRAME_W + INDEX_W;
  localparam int DEPTH    = NUM_FRAMES * TABLE_ENTRIES;
  localparam int ENTRY_W  = 4 + FRAME_W;

  // Field widths
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int OFFS_W   = 12;
  localparam int BASE_W   = 40;
  localparam int PFN_W    = PA_W - OFFS_W;

  // Entry bit positions
  localparam int E_PRESENT = 0;
  localparam int E_WRITE   = 1;
  localparam int E_USER    = 2;
  localparam int E_NX      = 3;
  localparam int E_FRAME   = 4;

  // Walk levels, counted down from the top table to the leaf table
  localparam logic [1:0] LVL_TOP  = 2'd3;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  typedef enum logic [1:0] {
    CMD_MAP       = 2'd0,
    CMD_UNMAP     = 2'd1,
    CMD_PROTECT   = 2'd2,
    CMD_TRANSLATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ALREADY     = 2'd1,
    ST_NOT_MAPPED  = 2'd2,
    ST_OUT_OF_MEM  = 2'd3
  } status_e;

  // Microprogram step addresses
  typedef enum logic [3:0] {
    S_CLEAR    = 4'd0,
    S_IDLE     = 4'd1,
    S_READ     = 4'd2,
    S_BRANCH   = 4'd3,
    S_CHECK    = 4'd4,
    S_LEVEL    = 4'd5,
    S_DESC     = 4'd6,
    S_LEAFOP   = 4'd7,
    S_MAPCHK   = 4'd8,
    S_MAPPRES  = 4'd9,
    S_POOL     = 4'd10,
    S_ERR_NM   = 4'd11,
    S_ERR_AM   = 4'd12,
    S_EMIT     = 4'd13,
    S_ERR_OOM  = 4'd14,
    S_ALLOC    = 4'd15
  } step_e;

  typedef enum logic [3:0] {
    U_NONE,
    U_CLEAR,
    U_LOAD,
    U_READ,
    U_DESC,
    U_LEAFOP,
    U_ALLOC,
    U_SET_NM,
    U_SET_AM,
    U_SET_OOM,
    U_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_MORE,
    C_BEAT,
    C_CMD_MAP,
    C_PRESENT,
    C_LEAF,
    C_POOL_EMPTY,
    C_OUT_BUSY
  } cond_e;

  // One control word: action, branch condition, target if true, target if false
  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    step_e jmp;
    step_e nxt;
  } uword_t;

  function automatic uword_t ucode(step_e s);
    uword_t w;
    unique case (s)
      S_CLEAR:   w = '{U_CLEAR,  C_CLR_MORE,   S_CLEAR,  S_IDLE};
      S_IDLE:    w = '{U_LOAD,   C_BEAT,       S_READ,   S_IDLE};
      S_READ:    w = '{U_READ,   C_ALWAYS,     S_BRANCH, S_BRANCH};
      S_BRANCH:  w = '{U_NONE,   C_CMD_MAP,    S_MAPCHK, S_CHECK};
      S_CHECK:   w = '{U_NONE,   C_PRESENT,    S_LEVEL,  S_ERR_NM};
      S_LEVEL:   w = '{U_NONE,   C_LEAF,       S_LEAFOP, S_DESC};
      S_DESC:    w = '{U_DESC,   C_ALWAYS,     S_READ,   S_READ};
      S_LEAFOP:  w = '{U_LEAFOP, C_ALWAYS,     S_EMIT,   S_EMIT};
      S_MAPCHK:  w = '{U_NONE,   C_PRESENT,    S_MAPPRES, S_POOL};
      S_MAPPRES: w = '{U_NONE,   C_LEAF,       S_ERR_AM, S_DESC};
      S_POOL:    w = '{U_NONE,   C_POOL_EMPTY, S_ERR_OOM, S_ALLOC};
      S_ERR_NM:  w = '{U_SET_NM, C_ALWAYS,     S_EMIT,   S_EMIT};
      S_ERR_AM:  w = '{U_SET_AM, C_ALWAYS,     S_EMIT,   S_EMIT};
      S_EMIT:    w = '{U_EMIT,   C_OUT_BUSY,   S_EMIT,   S_IDLE};
      S_ERR_OOM: w = '{U_SET_OOM, C_ALWAYS,    S_EMIT,   S_EMIT};
      S_ALLOC:   w = '{U_ALLOC,  C_LEAF,       S_EMIT,   S_READ};
      default:   w = '{U_NONE,   C_ALWAYS,     S_IDLE,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/flptw_if.sv]
// Valid/ready channel interfaces of the page-table walker: command and response.
// Depends on flptw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface flptw_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [1:0]                     root_frame;
  logic [flptw_pkg::VA_W-1:0]     vaddr;
  logic                           user_allowed;
  logic                           write_allowed;
  logic                           exec_allowed;

  modport source (output valid, command, root_frame, vaddr,
                  user_allowed, write_allowed, exec_allowed, input ready);
  modport sink   (input valid, command, root_frame, vaddr,
                  user_allowed, write_allowed, exec_allowed, output ready);
endinterface

interface flptw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [flptw_pkg::PA_W-1:0]     physical_address;
  logic                           leaf_user;
  logic                           leaf_writable;
  logic                           leaf_executable;

  modport source (output valid, status, physical_address, leaf_user,
                  leaf_writable, leaf_executable, input ready);
  modport sink   (input valid, status, physical_address, leaf_user,
                  leaf_writable, leaf_executable, output ready);
endinterface

`default_nettype wire

[rtl/core/four_level_page_table_walker.sv]
// Four-level page-table walker: microcoded sequencer, entry store and result register.
// Depends on flptw_pkg and the channel interfaces in flptw_if.sv.
//
// Usage: one command beat on cmd_i (map, unmap, protect, translate) yields
// exactly one response beat on rsp_o. Commands are taken one at a time: cmd_i.ready
// is high only while the sequencer sits at its idle step. Each walked level runs
// microcode steps over the single-port entry store (read, branch, check, descend
// or allocate); a walk stops early on an error. The result lands in an output
// register; the next command is accepted while that beat waits. If the receiver
// stalls with a result still held, the sequencer waits at its emit step until
// rsp_o.ready frees the register.
// After reset the sequencer clears all NUM_FRAMES * TABLE_ENTRIES (32768) entries
// of the entry store to not-present, one entry per cycle; no command is accepted
// during that pass. The pool base register is written through cfg_wr_en_i and
// cfg_wr_data_i; the user is to write it only while the block is idle, or during
// the clearing pass, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_wr_en_i,
  input  wire [flptw_pkg::BASE_W-1:0]       cfg_wr_data_i,
  flptw_cmd_if.sink                         cmd_i,
  flptw_rsp_if.source                       rsp_o
);

  localparam int FW = flptw_pkg::FRAME_W;
  localparam int EW = flptw_pkg::ENTRY_W;
  localparam int AW = flptw_pkg::ADDR_W;
  localparam int IW = flptw_pkg::INDEX_W;
  localparam int NW = flptw_pkg::FREE_W;

  // Sequencer and datapath registers
  flptw_pkg::step_e                pc_q, pc_d;
  logic [AW-1:0]                   clr_q;
  logic [NW-1:0]                   free_q;
  logic [flptw_pkg::BASE_W-1:0]    base_q;
  logic                            out_valid_q;

  flptw_pkg::cmd_e                 cmd_q;
  logic [flptw_pkg::VA_W-1:0]      va_q;
  logic                            u_q, w_q, x_q;
  logic [FW-1:0]                   tbl_q;
  logic [1:0]                      lvl_q;
  flptw_pkg::status_e              status_q;
  logic [flptw_pkg::PA_W-1:0]      pa_q;
  logic                            lu_q, lw_q, lx_q;

  logic [1:0]                      out_status_q;
  logic [flptw_pkg::PA_W-1:0]      out_pa_q;
  logic                            out_u_q, out_w_q, out_x_q;

  // Entry store
  logic [EW-1:0]                   mem [flptw_pkg::DEPTH];
  logic [EW-1:0]                   rdata_q;
  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_addr;
  logic [EW-1:0]                   mem_wdata;

  flptw_pkg::uword_t               uw;
  logic                            beat, cond_true, out_busy;
  logic [IW-1:0]                   idx;
  logic [FW-1:0]                   new_frame;
  logic [FW-1:0]                   rd_frame;
  logic [flptw_pkg::PFN_W-1:0]     pfn_sum;

  function automatic logic [EW-1:0] make_entry(logic [FW-1:0] fr, logic u, logic w,
                                               logic nx);
    logic [EW-1:0] e;
    e = '0;
    e[flptw_pkg::E_PRESENT] = 1'b1;
    e[flptw_pkg::E_WRITE]   = w;
    e[flptw_pkg::E_USER]    = u;
    e[flptw_pkg::E_NX]      = nx;
    e[EW-1:flptw_pkg::E_FRAME] = fr;
    return e;
  endfunction

  assign uw        = flptw_pkg::ucode(pc_q);
  assign beat      = cmd_i.valid && cmd_i.ready;
  assign out_busy  = out_valid_q && !rsp_o.ready;
  assign new_frame = free_q[FW-1:0];
  assign rd_frame  = rdata_q[EW-1:flptw_pkg::E_FRAME];
  assign pfn_sum   = base_q + flptw_pkg::PFN_W'(rd_frame);

  // Pick the 9-bit index of the current level
  always_comb begin
    unique case (lvl_q)
      2'd3:    idx = va_q[47:39];
      2'd2:    idx = va_q[38:30];
      2'd1:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  // Evaluate the branch condition of the current control word
  always_comb begin
    unique case (uw.cond)
      flptw_pkg::C_ALWAYS:     cond_true = 1'b1;
      flptw_pkg::C_CLR_MORE:   cond_true = (clr_q != AW'(flptw_pkg::DEPTH - 1));
      flptw_pkg::C_BEAT:       cond_true = beat;
      flptw_pkg::C_CMD_MAP:    cond_true = (cmd_q == flptw_pkg::CMD_MAP);
      flptw_pkg::C_PRESENT:    cond_true = rdata_q[flptw_pkg::E_PRESENT];
      flptw_pkg::C_LEAF:       cond_true = (lvl_q == flptw_pkg::LVL_LEAF);
      flptw_pkg::C_POOL_EMPTY: cond_true = (free_q >= NW'(flptw_pkg::NUM_FRAMES));
      flptw_pkg::C_OUT_BUSY:   cond_true = out_busy;
      default:                 cond_true = 1'b1;
    endcase
  end

  assign pc_d = cond_true ? uw.jmp : uw.nxt;

  // Drive the store port from the current action
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {tbl_q, idx};
    mem_wdata = '0;
    unique case (uw.uop)
      flptw_pkg::U_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      flptw_pkg::U_READ: mem_re = 1'b1;
      flptw_pkg::U_ALLOC: begin
        mem_we = 1'b1;
        if (lvl_q == flptw_pkg::LVL_LEAF) begin
          mem_wdata = make_entry(new_frame, u_q, w_q, !x_q);
        end else begin
          mem_wdata = make_entry(new_frame, 1'b1, 1'b1, 1'b0);
        end
      end
      flptw_pkg::U_LEAFOP: begin
        if (cmd_q == flptw_pkg::CMD_UNMAP) begin
          mem_we = 1'b1;
        end else if (cmd_q == flptw_pkg::CMD_PROTECT) begin
          mem_we    = 1'b1;
          mem_wdata = make_entry(rd_frame, u_q, w_q, !x_q);
        end
      end
      default: ;
    endcase
  end

  // Entry store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= flptw_pkg::S_CLEAR;
      clr_q       <= '0;
      free_q      <= NW'(flptw_pkg::ROOT_FRAMES);
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (uw.uop == flptw_pkg::U_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (uw.uop == flptw_pkg::U_ALLOC) begin
        free_q <= free_q + NW'(1);
      end
      if (cfg_wr_en_i) begin
        base_q <= cfg_wr_data_i;
      end
      // Load a finished result, drop a taken one
      if (uw.uop == flptw_pkg::U_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (uw.uop)
      flptw_pkg::U_LOAD: begin
        if (beat) begin
          cmd_q    <= flptw_pkg::cmd_e'(cmd_i.command);
          va_q     <= cmd_i.vaddr;
          u_q      <= cmd_i.user_allowed;
          w_q      <= cmd_i.write_allowed;
          x_q      <= cmd_i.exec_allowed;
          tbl_q    <= FW'(cmd_i.root_frame);
          lvl_q    <= flptw_pkg::LVL_TOP;
          status_q <= flptw_pkg::ST_OK;
          pa_q     <= '0;
          lu_q     <= 1'b0;
          lw_q     <= 1'b0;
          lx_q     <= 1'b0;
        end
      end
      flptw_pkg::U_DESC: begin
        tbl_q <= rd_frame;
        lvl_q <= lvl_q - 2'd1;
      end
      flptw_pkg::U_ALLOC: begin
        tbl_q <= new_frame;
        lvl_q <= lvl_q - 2'd1;
      end
      flptw_pkg::U_LEAFOP: begin
        if (cmd_q == flptw_pkg::CMD_TRANSLATE) begin
          pa_q <= {pfn_sum, va_q[flptw_pkg::OFFS_W-1:0]};
          lu_q <= rdata_q[flptw_pkg::E_USER];
          lw_q <= rdata_q[flptw_pkg::E_WRITE];
          lx_q <= !rdata_q[flptw_pkg::E_NX];
        end
      end
      flptw_pkg::U_SET_NM:  status_q <= flptw_pkg::ST_NOT_MAPPED;
      flptw_pkg::U_SET_AM:  status_q <= flptw_pkg::ST_ALREADY;
      flptw_pkg::U_SET_OOM: status_q <= flptw_pkg::ST_OUT_OF_MEM;
      flptw_pkg::U_EMIT: begin
        if (!out_busy) begin
          out_status_q <= status_q;
          out_pa_q     <= pa_q;
          out_u_q      <= lu_q;
          out_w_q      <= lw_q;
          out_x_q      <= lx_q;
        end
      end
      default: ;
    endcase
  end

  // Channel outputs
  assign cmd_i.ready            = (pc_q == flptw_pkg::S_IDLE);
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.physical_address = out_pa_q;
  assign rsp_o.leaf_user        = out_u_q;
  assign rsp_o.leaf_writable    = out_w_q;
  assign rsp_o.leaf_executable  = out_x_q;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NW'(flptw_pkg::NUM_FRAMES))
    else $error("allocator ran past the pool");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == flptw_pkg::S_ALLOC) |-> (free_q < NW'(flptw_pkg::NUM_FRAMES)))
    else $error("allocation with an empty pool");

  a_beat_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (pc_q == flptw_pkg::S_READ))
    else $error("accepted command did not start a walk");

  a_rsp_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> ($past(pc_q) == flptw_pkg::S_EMIT))
    else $error("response raised outside the emit step");
`endif

endmodule

`default_nettype wire
